// ===== rtl/hdlc_pkg.sv =====
// Package for the HDLC async deframer: frame constants, result kinds and the
// structs passed between the top level and the decode core. No dependencies.
package hdlc_pkg;

    localparam int unsigned MAX_FRAME  = 4096;
    localparam int unsigned CNT_W      = $clog2(MAX_FRAME);
    localparam int unsigned HOLD_DEPTH = 2;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_COMMIT  = 2'd1,
        KIND_DISCARD = 2'd2
    } t_kind;

    // One received byte presented to the decode core for processing.
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_step;

    // One result produced by the decode core.
    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        t_kind      kind;
    } t_res;

endpackage

// ===== rtl/hdlc_in_if.sv =====
// Input channel of the HDLC async deframer: valid/ready plus one raw byte.
// Depends on nothing.
interface hdlc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/hdlc_out_if.sv =====
// Result channel of the HDLC async deframer: valid/ready, byte and kind.
// Depends on hdlc_pkg for the kind type.
interface hdlc_out_if;
    import hdlc_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    t_kind      kind;

    modport source (output valid, output out_byte, output kind, input ready);
    modport sink   (input valid, input out_byte, input kind, output ready);
endinterface

// ===== rtl/hdlc_async_deframer.sv =====
// Path: an accepted byte is held in the input register, decoded combinationally by the
// core, and its result (if any) is registered in the result register that drives o_res.
// Throughput: one byte per cycle, limited only by the result request being taken.
// Reset: synchronous, active low; clears the frame count, the escape mark and
// both pipeline valid bits, and sets forward_enable to 1.
module hdlc_async_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    hdlc_in_if.sink    i_rx,
    hdlc_out_if.source o_res
);
    import hdlc_pkg::*;

    // Input register: holds one accepted byte until the decode core takes it.
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;

    // Result register: drives the output channel directly.
    t_res       r_out;

    // The forward_enable configuration register.
    logic       r_fwd;

    logic       w_out_free;
    logic       w_s1_adv;
    t_step      w_step;
    t_res       w_core_res;

    // The result register can load when it is empty or its request is being
    // taken this cycle. The input register moves on whenever that holds,
    // whether or not its byte produces a result.
    assign w_out_free = !r_out.valid || o_res.ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;

    // A new byte is taken while the input register is empty or draining, so
    // a waiting result never stops an empty pipeline from accepting.
    assign i_rx.ready = !r_s1_valid || w_out_free;

    assign w_step.valid   = w_s1_adv;
    assign w_step.rx_byte = r_s1_byte;

    hdlc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_fwd_en (r_fwd),
        .o_res    (w_core_res)
    );

    // The result register is loaded whole here; only its valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_out.valid <= 1'b0;
            r_fwd <= 1'b1;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out.valid    <= w_core_res.valid;
                r_out.out_byte <= w_core_res.out_byte;
                r_out.kind     <= w_core_res.kind;
            end
            if (i_cfg_wr_en) begin
                r_fwd <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_s1_byte <= i_rx.rx_byte;
        end
    end

    assign o_res.valid    = r_out.valid;
    assign o_res.out_byte = r_out.out_byte;
    assign o_res.kind     = r_out.kind;

`ifndef ASSERT_OFF
    // A result can only appear after a byte sat in the input register.
    a_res_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_s1_valid))
        else $error("result appeared without a byte in the input register");

    // A byte stuck in the input register is neither lost nor overwritten.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1_byte)))
        else $error("stalled input byte was lost or overwritten");

    // A commit marker is only produced while forwarding is enabled.
    a_commit_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_COMMIT)) |-> r_fwd)
        else $error("commit marker with forwarding disabled");

    // Frame markers carry a zero byte.
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind != KIND_DATA)) |-> (o_res.out_byte == 8'h00))
        else $error("frame marker with non-zero byte");
`endif

endmodule

// ===== rtl/hdlc_core.sv =====
// Decode core of the HDLC async deframer: flag and escape handling, the
// two-byte hold-back line and the frame byte count. Depends on hdlc_pkg.
module hdlc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hdlc_pkg::t_step i_step,
    input  logic            i_fwd_en,
    output hdlc_pkg::t_res  o_res
);
    import hdlc_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_esc;
    logic             n_esc;
    logic [7:0]       r_held_old;
    logic [7:0]       r_held_new;
    logic [7:0]       w_byte;
    logic [CNT_W:0]   w_count_inc;
    logic             w_full;
    logic             w_payload;

    assign w_byte      = r_esc ? (i_step.rx_byte ^ ESC_XOR) : i_step.rx_byte;
    assign w_count_inc = (CNT_W + 1)'(r_count) + (CNT_W + 1)'(1);
    assign w_full      = (w_count_inc == (CNT_W + 1)'(MAX_FRAME));
    assign w_payload   = i_step.valid && (i_step.rx_byte != FLAG_BYTE)
                         && (i_step.rx_byte != ESC_BYTE);

    always_comb begin
        n_count        = r_count;
        n_esc          = r_esc;
        o_res.valid    = 1'b0;
        o_res.out_byte = 8'h00;
        o_res.kind     = KIND_DATA;
        if (i_step.valid) begin
            priority if (i_step.rx_byte == FLAG_BYTE) begin
                n_count = '0;
                n_esc   = 1'b0;
                if (r_count > CNT_W'(HOLD_DEPTH)) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = i_fwd_en ? KIND_COMMIT : KIND_DISCARD;
                end
            end else if (i_step.rx_byte == ESC_BYTE) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                if (w_full) begin
                    // Oversized frame: drop it and start counting afresh.
                    n_count     = '0;
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_DISCARD;
                end else begin
                    n_count = w_count_inc[CNT_W-1:0];
                    if (r_count >= CNT_W'(HOLD_DEPTH)) begin
                        o_res.valid    = 1'b1;
                        o_res.out_byte = r_held_old;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_esc   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_esc   <= n_esc;
        end
    end

    // The hold-back line is only read after two payload bytes have entered it.
    always_ff @(posedge i_clk) begin
        if (w_payload) begin
            r_held_old <= r_held_new;
            r_held_new <= w_byte;
        end
    end

endmodule

// ===== tb/sv/tb_deframer_pkg.sv =====
// Scoreboard for the HDLC async deframer testbench: predicts the result of
// every accepted byte and checks each result taken from the block against it.
// Depends on hdlc_pkg for the frame constants and the result kind type.
package tb_deframer_pkg;
    import hdlc_pkg::*;

    typedef struct {
        logic [7:0] data;
        t_kind      kind;
    } t_deframe_expect;

    class deframe_scoreboard;
        bit              forward_en;
        int unsigned     payload_count;
        bit              esc_mark;
        logic [7:0]      hold_q [2];
        t_deframe_expect expected_q [$];
        int unsigned     mismatches;
        int unsigned     n_rx;
        int unsigned     n_data;
        int unsigned     n_commit;
        int unsigned     n_discard;

        function new();
            forward_en    = 1'b1;
            payload_count = 0;
            esc_mark      = 1'b0;
            hold_q[0]     = '0;
            hold_q[1]     = '0;
            mismatches    = 0;
            n_rx          = 0;
            n_data        = 0;
            n_commit      = 0;
            n_discard     = 0;
        endfunction

        function void set_forward(bit en);
            forward_en = en;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void push_result(logic [7:0] data, t_kind kind);
            t_deframe_expect e;
            e.data = data;
            e.kind = kind;
            expected_q.push_back(e);
        endfunction

        // Works out what one accepted received byte leads to.
        function void note_rx_byte(logic [7:0] rx);
            logic [7:0] b;
            logic [7:0] oldest;
            bit         have_data;
            b = rx;
            n_rx++;
            if (b == FLAG_BYTE) begin
                if (payload_count > HOLD_DEPTH)
                    push_result(8'h00, forward_en ? KIND_COMMIT : KIND_DISCARD);
                payload_count = 0;
                esc_mark      = 1'b0;
                return;
            end
            if (b == ESC_BYTE) begin
                esc_mark = 1'b1;
                return;
            end
            if (esc_mark) begin
                b        = b ^ ESC_XOR;
                esc_mark = 1'b0;
            end
            have_data = payload_count >= HOLD_DEPTH;
            oldest    = hold_q[0];
            hold_q[0] = hold_q[1];
            hold_q[1] = b;
            payload_count++;
            if (payload_count >= MAX_FRAME) begin
                payload_count = 0;
                push_result(8'h00, KIND_DISCARD);
            end else if (have_data) begin
                push_result(oldest, KIND_DATA);
            end
        endfunction

        function void check_result(logic [7:0] got_data, t_kind got_kind);
            t_deframe_expect e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result byte %02h kind %0d",
                             $realtime, got_data, got_kind);
                return;
            end
            e = expected_q.pop_front();
            if (got_data !== e.data || got_kind !== e.kind) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result mismatch: expected byte %02h kind %0d, got byte %02h kind %0d",
                             $realtime, e.data, e.kind, got_data, got_kind);
            end
            case (e.kind)
                KIND_DATA:   n_data++;
                KIND_COMMIT: n_commit++;
                default:     n_discard++;
            endcase
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top level of the HDLC async deframer testbench: clock, reset, stimulus,
// random back-pressure and the end-of-run verdict.
// Depends on hdlc_pkg, both channel interfaces, the deframer and tb_deframer_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hdlc_pkg::*;
    import tb_deframer_pkg::*;

    // Cycles allowed after the last expected result for the two-stage pipeline
    // to empty, covering bytes that produce nothing.
    localparam int SETTLE_CYCLES = 6;

    logic i_clk;
    logic i_rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    hdlc_in_if  rx_if ();
    hdlc_out_if res_if ();

    hdlc_async_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_rx          (rx_if),
        .o_res         (res_if)
    );

    deframe_scoreboard deframe_sb;

    // When clear, neither the byte source nor the result sink inserts gaps.
    bit          idle_on;
    int unsigned bytes_sent;

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results are sampled at the rising edge, as are accepted requests on the
    // byte channel. The byte is noted before the result is checked, so an
    // expectation raised at this edge always sits behind older ones.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready)
                deframe_sb.note_rx_byte(rx_if.rx_byte);
            if (res_if.valid && res_if.ready)
                deframe_sb.check_result(res_if.out_byte, res_if.kind);
        end
    end

    // Result sink: ready drops for random bursts while idling is enabled.
    // Exactly one assignment per falling edge.
    initial begin : result_sink
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left   = $urandom_range(1, 6) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Presents one byte and waits for the request to be taken. Called and
    // returns at a falling edge, so valid is never lowered and raised in the
    // same time step when requests follow back to back.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Sends one payload byte, escaping it where the framing requires and now
    // and then where it does not (only if the escaped form is not itself a
    // flag or an escape).
    task automatic send_payload(input logic [7:0] b);
        logic [7:0] alt;
        alt = b ^ ESC_XOR;
        if (b == FLAG_BYTE || b == ESC_BYTE ||
            ($urandom_range(0, 9) == 0 && alt != FLAG_BYTE && alt != ESC_BYTE)) begin
            send_byte(ESC_BYTE);
            send_byte(alt);
        end else begin
            send_byte(b);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed frames with random content and length; the rest is
    // raw noise rich in flags and escapes, which breaks frames and leaves
    // escapes dangling in front of flags.
    task automatic send_random_traffic(input int unsigned n_bytes);
        int unsigned first;
        int unsigned len;
        int unsigned k;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes) begin
            if ($urandom_range(0, 9) < 8) begin
                send_byte(FLAG_BYTE);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(0, 8);
                for (k = 0; k < len; k++)
                    send_payload(8'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    send_byte(pick_byte());
            end
        end
    endtask

    // Stops sending and waits until every expected result has been taken,
    // then lets the pipeline empty. Starts and ends at a falling edge.
    task automatic wait_results_drained();
        rx_if.valid <= 1'b0;
        while (deframe_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes forward_enable once the block has gone quiet.
    task automatic write_forward(input bit en);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        deframe_sb.set_forward(en);
    endtask

    // One frame that runs past the size limit: the byte that reaches the limit
    // gives a discard marker instead of data, and counting restarts so the
    // last few bytes form a short frame that still commits.
    task automatic send_oversized_frame();
        int unsigned k;
        send_byte(FLAG_BYTE);
        for (k = 0; k < MAX_FRAME + 3; k++)
            send_payload(8'($urandom_range(0, 255)));
        send_byte(FLAG_BYTE);
    endtask

    initial begin : stimulus
        deframe_sb    = new();
        idle_on       = 1'b1;
        bytes_sent    = 0;
        i_rst_n       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_forward(1'b1);

        // Directed part. A flag straight after reset and a second flag give
        // empty frames; then frames of one and two bytes end silently.
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(8'h00);
        send_byte(FLAG_BYTE);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(FLAG_BYTE);
        // Four payload bytes, two of them escaped flag and escape values:
        // the extremes come out as data, the last two are held back as CRC.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE ^ ESC_XOR);
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE ^ ESC_XOR);
        send_byte(FLAG_BYTE);
        // A doubled escape still marks only the next byte; an escape just
        // before a flag is cleared by it, and the frame of one byte is silent.
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);
        send_byte(8'h41);
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
        // Exactly three payload bytes: one data byte, then a commit.
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(FLAG_BYTE);

        // Random frames with forwarding on, broken by one full pause.
        send_random_traffic(100);
        wait_results_drained();
        send_random_traffic(100);

        // Forwarding off: frames longer than two payload bytes end with a discard marker.
        write_forward(1'b0);
        send_random_traffic(150);

        write_forward(1'b1);
        send_oversized_frame();

        write_forward(1'b0);
        send_random_traffic(100);

        // Last part runs flat out on both sides.
        write_forward(1'b1);
        idle_on = 1'b0;
        send_random_traffic(150);

        wait_results_drained();

        $display("Covered %0d bytes: %0d data bytes, %0d commits, %0d discards checked.",
                 deframe_sb.n_rx, deframe_sb.n_data, deframe_sb.n_commit,
                 deframe_sb.n_discard);
        $display("Forwarding toggled both ways, one frame ran past the size limit; %0d mismatches.",
                 deframe_sb.mismatches);
        if (deframe_sb.mismatches == 0 && deframe_sb.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Well beyond the slowest correct run, which stays under a millisecond.
    initial begin : watchdog
        #5ms;
        $display("Timed out with %0d results still expected.", deframe_sb.pending());
        $display("tb_top: errors");
        $finish;
    end

endmodule
